// ----- rtl/binary_min_heap_queue_defines.svh -----
// assertion macros for the binary min heap queue checker
// no dependencies; included by the checker file only
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication, off during reset
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition that must hold in the cycle after reset is seen
`define BMHQ_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- rtl/bmhq_pkg.sv -----
// shared types and constants for the binary min heap queue
// used by the controller, datapath, top level and checker
package bmhq_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_FIN,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_INS,
    DP_LOAD_REM,
    DP_LOAD_FULL,
    DP_LOAD_EMPTY,
    DP_LOAD_QUERY,
    DP_UP_READ,
    DP_UP_MOVE,
    DP_LAST_LOAD,
    DP_DN_READ,
    DP_DN_MOVE,
    DP_WRITE_VAL,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic full;
    logic empty;
    logic count_one;
    logic parent_zero;
    logic up_less;
    logic dn_move;
  } dp_stat_t;

endpackage

// ----- rtl/binary_min_heap_queue.sv -----
// binary min heap priority queue of signed 32-bit values, top level
// depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath
//
// input channel: cmd (insert, remove minimum, query) and value, taken when
// in_valid is high and in_stall is low; one item is worked on at a time
// output channel: one result per item (removed_value, min_value,
// entry_count, is_empty, status), taken when out_valid is high and
// out_stall is low; results held in an output register
// insert climbs one level per read-then-compare step on the heap memory,
// and remove sinks the moved entry one level per such step; query,
// rejected insert, empty remove and removing the only entry do no sift
// the next item is taken the cycle after the result is loaded, even while
// that result still waits on a stalled receiver; a stall only holds the
// block if a second result is ready before the first was taken
// reset empties the queue and drops any pending result; heap memory is not
// cleared since only values from occupied slots are ever used
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         cmd,
  input  logic signed [bmhq_pkg::VAL_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bmhq_pkg::VAL_W-1:0]  removed_value,
  output logic signed [bmhq_pkg::VAL_W-1:0]  min_value,
  output logic [bmhq_pkg::CNT_OUT_W-1:0]     entry_count,
  output logic                               is_empty,
  output logic [1:0]                         status
);

  bmhq_pkg::ctrl_cmd_t ctl;
  bmhq_pkg::dp_stat_t  st;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .ctl       (ctl)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (value),
    .ctl           (ctl),
    .st            (st),
    .removed_value (removed_value),
    .min_value     (min_value),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .status        (status)
  );

endmodule

// ----- rtl/bmhq_datapath.sv -----
// heap memory, sift registers, comparators and result registers
// depends on bmhq_pkg; driven by bmhq_ctrl through ctrl_cmd_t
module bmhq_datapath #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          cmd,
  input  logic signed [bmhq_pkg::VAL_W-1:0]   value,
  input  bmhq_pkg::ctrl_cmd_t                 ctl,
  output bmhq_pkg::dp_stat_t                  st,
  output logic signed [bmhq_pkg::VAL_W-1:0]   removed_value,
  output logic signed [bmhq_pkg::VAL_W-1:0]   min_value,
  output logic [bmhq_pkg::CNT_OUT_W-1:0]      entry_count,
  output logic                                is_empty,
  output logic [1:0]                          status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = CW + 1;
  localparam int XW = CW + bmhq_pkg::CNT_OUT_W;

  logic signed [bmhq_pkg::VAL_W-1:0] mem [CAPACITY];
  logic signed [bmhq_pkg::VAL_W-1:0] rdata0;
  logic signed [bmhq_pkg::VAL_W-1:0] rdata1;
  logic signed [bmhq_pkg::VAL_W-1:0] val;
  logic signed [bmhq_pkg::VAL_W-1:0] root;
  logic signed [bmhq_pkg::VAL_W-1:0] res_removed;
  logic [1:0]                        res_status;
  logic [CW-1:0]                     count;
  logic [AW-1:0]                     pos;

  logic [CW-1:0]                     count_dec;
  logic [AW-1:0]                     parent;
  logic [IW-1:0]                     left;
  logic [IW-1:0]                     right;
  logic                              left_ok;
  logic                              right_ok;
  logic                              left_lt;
  logic                              right_lt;
  logic signed [bmhq_pkg::VAL_W-1:0] cur_min;
  logic signed [bmhq_pkg::VAL_W-1:0] child;
  logic [IW-1:0]                     best;
  logic [XW-1:0]                     count_ext;

  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [bmhq_pkg::VAL_W-1:0] wdata;
  logic [AW-1:0]                     raddr0;
  logic [AW-1:0]                     raddr1;

  assign count_dec = count - CW'(1);
  assign parent    = (pos - AW'(1)) >> 1;
  assign left      = IW'({pos, 1'b1});
  assign right     = left + IW'(1);
  assign left_ok   = left < IW'(count);
  assign right_ok  = right < IW'(count);
  assign left_lt   = left_ok && (rdata0 < val);
  assign cur_min   = left_lt ? rdata0 : val;
  assign right_lt  = right_ok && (rdata1 < cur_min);
  assign child     = right_lt ? rdata1 : rdata0;
  assign best      = right_lt ? right : left;
  assign count_ext = XW'(count);

  assign st.is_insert   = (cmd == bmhq_pkg::CMD_INSERT);
  assign st.is_remove   = (cmd == bmhq_pkg::CMD_REMOVE);
  assign st.full        = (count == CW'(CAPACITY));
  assign st.empty       = (count == '0);
  assign st.count_one   = (count == CW'(1));
  assign st.parent_zero = (parent == '0);
  assign st.up_less     = (val < rdata0);
  assign st.dn_move     = left_lt || right_lt;

  always_comb begin
    we     = 1'b0;
    waddr  = pos;
    wdata  = val;
    raddr0 = left[AW-1:0];
    raddr1 = right[AW-1:0];
    unique case (ctl.op)
      bmhq_pkg::DP_UP_READ:   raddr0 = parent;
      bmhq_pkg::DP_LOAD_REM:  raddr0 = count_dec[AW-1:0];
      bmhq_pkg::DP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rdata0;
      end
      bmhq_pkg::DP_DN_MOVE: begin
        we    = 1'b1;
        wdata = child;
      end
      bmhq_pkg::DP_WRITE_VAL: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctl.op)
        bmhq_pkg::DP_LOAD_INS: count <= count + CW'(1);
        bmhq_pkg::DP_LOAD_REM: count <= count_dec;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      bmhq_pkg::DP_LOAD_INS: begin
        val         <= value;
        pos         <= count[AW-1:0];
        res_removed <= '0;
        res_status  <= bmhq_pkg::STATUS_OK;
      end
      bmhq_pkg::DP_LOAD_REM: begin
        res_removed <= root;
        res_status  <= bmhq_pkg::STATUS_OK;
      end
      bmhq_pkg::DP_LOAD_FULL: begin
        res_removed <= '0;
        res_status  <= bmhq_pkg::STATUS_FULL;
      end
      bmhq_pkg::DP_LOAD_EMPTY: begin
        res_removed <= '0;
        res_status  <= bmhq_pkg::STATUS_EMPTY;
      end
      bmhq_pkg::DP_LOAD_QUERY: begin
        res_removed <= '0;
        res_status  <= bmhq_pkg::STATUS_OK;
      end
      bmhq_pkg::DP_UP_MOVE: pos <= parent;
      bmhq_pkg::DP_LAST_LOAD: begin
        val <= rdata0;
        pos <= '0;
      end
      bmhq_pkg::DP_DN_MOVE: pos <= best[AW-1:0];
      bmhq_pkg::DP_OUT_LOAD: begin
        removed_value <= res_removed;
        min_value     <= (count != '0) ? root : '0;
        entry_count   <= count_ext[bmhq_pkg::CNT_OUT_W-1:0];
        is_empty      <= (count == '0);
        status        <= res_status;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// sequencing state machine for insert, remove and query items
// depends on bmhq_pkg; commands bmhq_datapath, owns the output valid
module bmhq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bmhq_pkg::dp_stat_t  st,
  output bmhq_pkg::ctrl_cmd_t ctl
);

  bmhq_pkg::state_t state;
  bmhq_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmhq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl.op         = bmhq_pkg::DP_NOP;
    in_stall       = (state != bmhq_pkg::S_IDLE);
    out_valid_next = out_valid && out_stall;
    unique case (state)
      bmhq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (st.is_insert) begin
            if (st.full) begin
              ctl.op     = bmhq_pkg::DP_LOAD_FULL;
              state_next = bmhq_pkg::S_OUT;
            end else begin
              ctl.op     = bmhq_pkg::DP_LOAD_INS;
              state_next = st.empty ? bmhq_pkg::S_FIN : bmhq_pkg::S_UP_RD;
            end
          end else if (st.is_remove) begin
            if (st.empty) begin
              ctl.op     = bmhq_pkg::DP_LOAD_EMPTY;
              state_next = bmhq_pkg::S_OUT;
            end else begin
              ctl.op     = bmhq_pkg::DP_LOAD_REM;
              state_next = st.count_one ? bmhq_pkg::S_OUT : bmhq_pkg::S_DN_LOAD;
            end
          end else begin
            ctl.op     = bmhq_pkg::DP_LOAD_QUERY;
            state_next = bmhq_pkg::S_OUT;
          end
        end
      end
      bmhq_pkg::S_UP_RD: begin
        ctl.op     = bmhq_pkg::DP_UP_READ;
        state_next = bmhq_pkg::S_UP_CMP;
      end
      bmhq_pkg::S_UP_CMP: begin
        if (st.up_less) begin
          ctl.op     = bmhq_pkg::DP_UP_MOVE;
          state_next = st.parent_zero ? bmhq_pkg::S_FIN : bmhq_pkg::S_UP_RD;
        end else begin
          ctl.op     = bmhq_pkg::DP_WRITE_VAL;
          state_next = bmhq_pkg::S_OUT;
        end
      end
      bmhq_pkg::S_FIN: begin
        ctl.op     = bmhq_pkg::DP_WRITE_VAL;
        state_next = bmhq_pkg::S_OUT;
      end
      bmhq_pkg::S_DN_LOAD: begin
        ctl.op     = bmhq_pkg::DP_LAST_LOAD;
        state_next = bmhq_pkg::S_DN_RD;
      end
      bmhq_pkg::S_DN_RD: begin
        ctl.op     = bmhq_pkg::DP_DN_READ;
        state_next = bmhq_pkg::S_DN_CMP;
      end
      bmhq_pkg::S_DN_CMP: begin
        if (st.dn_move) begin
          ctl.op     = bmhq_pkg::DP_DN_MOVE;
          state_next = bmhq_pkg::S_DN_RD;
        end else begin
          ctl.op     = bmhq_pkg::DP_WRITE_VAL;
          state_next = bmhq_pkg::S_OUT;
        end
      end
      bmhq_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          ctl.op         = bmhq_pkg::DP_OUT_LOAD;
          out_valid_next = 1'b1;
          state_next     = bmhq_pkg::S_IDLE;
        end
      end
      default: state_next = bmhq_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/bmhq_checker.sv -----
// port-level checks for the binary min heap queue, bound to the top level
// depends on bmhq_pkg and binary_min_heap_queue_defines.svh
`include "binary_min_heap_queue_defines.svh"

module bmhq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bmhq_pkg::VAL_W-1:0] removed_value,
  input logic signed [bmhq_pkg::VAL_W-1:0] min_value,
  input logic [bmhq_pkg::CNT_OUT_W-1:0]    entry_count,
  input logic                              is_empty,
  input logic [1:0]                        status
);

  `BMHQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(removed_value) && $stable(min_value) && $stable(entry_count) && $stable(is_empty) && $stable(status), "stalled result changed")
  `BMHQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item taken while one is in work")
  `BMHQ_ASSERT_NOW(a_empty_fields, out_valid && is_empty, entry_count == '0 && min_value == '0, "empty result with nonzero count or minimum")
  `BMHQ_ASSERT_NOW(a_remove_empty, out_valid && status == bmhq_pkg::STATUS_EMPTY, is_empty && removed_value == '0, "failed remove on non-empty queue")
  `BMHQ_ASSERT_RESET(a_reset_idle, !out_valid && !in_stall, "not idle after reset")

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .removed_value (removed_value),
  .min_value     (min_value),
  .entry_count   (entry_count),
  .is_empty      (is_empty),
  .status        (status)
);
